/* rtl/core/three_point_derivative_estimate_unit_macros.svh */
// Assertion macros shared by the derivative estimate RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef THREE_POINT_DERIVATIVE_ESTIMATE_UNIT_MACROS_SVH
`define THREE_POINT_DERIVATIVE_ESTIMATE_UNIT_MACROS_SVH

// same-cycle implication
`define TPDE_ASSERT_IMP(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define TPDE_ASSERT_NEXT(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/tpde_pkg.sv */
// Shared types and constants for the three-point derivative estimate unit.
// No dependencies.
`timescale 1ns / 1ps

package tpde_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   typedef enum logic [1:0] {
      OP_FIRST  = 2'd0,
      OP_MIDDLE = 2'd1,
      OP_LAST   = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_SAT     = 2'd1,
      ST_DIVZERO = 2'd2
   } status_type;

   typedef struct packed {
      logic zero;   // coincident abscissae
      logic neg;    // quotient sign
      logic ovf;    // quotient beyond the output range
   } tpde_flags_type;

endpackage

/* rtl/core/tpde_arith.sv */
// Front end: differences, exact products, numerator select, magnitudes, range check.
// Seven register stages with per-stage valid; depends on tpde_pkg.
`timescale 1ns / 1ps

module tpde_arith import tpde_pkg::*; #(
   parameter int DW = DATA_WIDTH_DEF,
   parameter int FB = FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [1:0]                  in_opcode,
   input  logic signed [DW-1:0]        xa,
   input  logic signed [DW-1:0]        xb,
   input  logic signed [DW-1:0]        xc,
   input  logic signed [DW-1:0]        ya,
   input  logic signed [DW-1:0]        yb,
   input  logic signed [DW-1:0]        yc,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [3*(DW+1)+2+FB-1:0]    out_rem,
   output logic [3*(DW+1)-1:0]         out_div,
   output tpde_flags_type              out_flags
);

   localparam int WD = DW + 1;
   localparam int WM = 2 * WD;
   localparam int WP = 3 * WD;
   localparam int WN = WP + 2;
   localparam int RW = WN + FB;
   localparam int CW = RW + DW;
   localparam int NS = 7;

   logic [NS-1:0] v_ff, v_in;
   logic [NS:0]   rdy;

   always_comb begin
      rdy[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
      v_in[0] = rdy[0] ? in_valid : v_ff[0];
      for (int k = 1; k < NS; k++) begin
         v_in[k] = rdy[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NS-1];

   // stage 1: differences
   logic signed [WD-1:0] dab_in, dac_in, dbc_in, eab_in, eac_in, ebc_in;
   logic signed [WD-1:0] dab1_ff, dac1_ff, dbc1_ff, eab1_ff, eac1_ff, ebc1_ff;
   logic                 zero_in, zero1_ff;
   logic [1:0]           op1_ff;

   always_comb begin
      dab_in  = {xa[DW-1], xa} - {xb[DW-1], xb};
      dac_in  = {xa[DW-1], xa} - {xc[DW-1], xc};
      dbc_in  = {xb[DW-1], xb} - {xc[DW-1], xc};
      eab_in  = {ya[DW-1], ya} - {yb[DW-1], yb};
      eac_in  = {ya[DW-1], ya} - {yc[DW-1], yc};
      ebc_in  = {yb[DW-1], yb} - {yc[DW-1], yc};
      zero_in = (xa == xb) || (xa == xc) || (xb == xc);
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         dab1_ff  <= dab_in;
         dac1_ff  <= dac_in;
         dbc1_ff  <= dbc_in;
         eab1_ff  <= eab_in;
         eac1_ff  <= eac_in;
         ebc1_ff  <= ebc_in;
         zero1_ff <= zero_in;
         op1_ff   <= in_opcode;
      end
   end

   // stage 2: pairwise abscissa products
   logic signed [WM-1:0] m1_in, m2_in, m3_in, m1_ff, m2_ff, m3_ff;
   logic signed [WD-1:0] eab2_ff, eac2_ff, ebc2_ff, dbc2_ff;
   logic                 zero2_ff;
   logic [1:0]           op2_ff;

   always_comb begin
      m1_in = dac1_ff * dbc1_ff;
      m2_in = dab1_ff * dbc1_ff;
      m3_in = dab1_ff * dac1_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         m1_ff    <= m1_in;
         m2_ff    <= m2_in;
         m3_ff    <= m3_in;
         eab2_ff  <= eab1_ff;
         eac2_ff  <= eac1_ff;
         ebc2_ff  <= ebc1_ff;
         dbc2_ff  <= dbc1_ff;
         zero2_ff <= zero1_ff;
         op2_ff   <= op1_ff;
      end
   end

   // stage 3: split the wide factor, form partial products (p, q, r, den)
   logic signed [WD-1:0]   e3 [4];
   logic signed [WM-1:0]   m3s [4];
   logic signed [2*WD-1:0] hi_in [4];
   logic signed [2*WD:0]   lo_in [4];
   logic signed [2*WD-1:0] hi_ff [4];
   logic signed [2*WD:0]   lo_ff [4];
   logic                   zero3_ff;
   logic [1:0]             op3_ff;

   always_comb begin
      e3[0] = eab2_ff;  m3s[0] = m1_ff;
      e3[1] = eac2_ff;  m3s[1] = m2_ff;
      e3[2] = ebc2_ff;  m3s[2] = m3_ff;
      e3[3] = dbc2_ff;  m3s[3] = m3_ff;
      for (int i = 0; i < 4; i++) begin
         hi_in[i] = e3[i] * signed'(m3s[i][WM-1:WD]);
         lo_in[i] = e3[i] * signed'({1'b0, m3s[i][WD-1:0]});
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         hi_ff    <= hi_in;
         lo_ff    <= lo_in;
         zero3_ff <= zero2_ff;
         op3_ff   <= op2_ff;
      end
   end

   // stage 4: recombine partials into exact triple products
   logic [WP-1:0] sum_in [4];
   logic [WP-1:0] sum_ff [4];
   logic          zero4_ff;
   logic [1:0]    op4_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sum_in[i] = {hi_ff[i], {WD{1'b0}}}
                   + {{(WP-2*WD-1){lo_ff[i][2*WD]}}, lo_ff[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         sum_ff   <= sum_in;
         zero4_ff <= zero3_ff;
         op4_ff   <= op3_ff;
      end
   end

   // stage 5: numerator for the chosen point
   logic [WN-1:0] pe, qe, re, num_in, num_ff;
   logic [WP-1:0] den5_ff;
   logic          zero5_ff;

   always_comb begin
      pe = {{2{sum_ff[0][WP-1]}}, sum_ff[0]};
      qe = {{2{sum_ff[1][WP-1]}}, sum_ff[1]};
      re = {{2{sum_ff[2][WP-1]}}, sum_ff[2]};
      unique case (opcode_type'(op4_ff))
         OP_FIRST:  num_in = pe + qe - re;
         OP_MIDDLE: num_in = pe + re - qe;
         default:   num_in = qe + re - pe;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         num_ff   <= num_in;
         den5_ff  <= sum_ff[3];
         zero5_ff <= zero4_ff;
      end
   end

   // stage 6: magnitudes and sign
   logic [WN-1:0] absn_in, absn_ff;
   logic [WP-1:0] absd_in, absd6_ff;
   logic          neg6_ff, zero6_ff;

   always_comb begin
      absn_in = num_ff[WN-1] ? (~num_ff + WN'(1)) : num_ff;
      absd_in = den5_ff[WP-1] ? (~den5_ff + WP'(1)) : den5_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         absn_ff  <= absn_in;
         absd6_ff <= absd_in;
         neg6_ff  <= num_ff[WN-1] ^ den5_ff[WP-1];
         zero6_ff <= zero5_ff;
      end
   end

   // stage 7: scale the dividend, flag quotients too large for the output
   logic [RW-1:0]  rem_in, rem_ff;
   logic [WP-1:0]  absd7_ff;
   logic           ovf_in;
   tpde_flags_type flags_ff;

   always_comb begin
      rem_in = {absn_ff, {FB{1'b0}}};
      ovf_in = CW'(rem_in) >= {{(CW-WP-DW){1'b0}}, absd6_ff, {DW{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         rem_ff        <= rem_in;
         absd7_ff      <= absd6_ff;
         flags_ff.zero <= zero6_ff;
         flags_ff.neg  <= neg6_ff;
         flags_ff.ovf  <= ovf_in;
      end
   end

   assign out_rem   = rem_ff;
   assign out_div   = absd7_ff;
   assign out_flags = flags_ff;

endmodule

/* rtl/core/tpde_div_step.sv */
// One restoring-division stage: resolves a single quotient bit per register stage.
// Depends on tpde_pkg.
`timescale 1ns / 1ps

module tpde_div_step import tpde_pkg::*; #(
   parameter int DW    = DATA_WIDTH_DEF,
   parameter int RW    = 3 * (DATA_WIDTH_DEF + 1) + 2 + FRAC_BITS_DEF,
   parameter int WP    = 3 * (DATA_WIDTH_DEF + 1),
   parameter int SHIFT = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [RW-1:0]  in_rem,
   input  logic [WP-1:0]  in_div,
   input  logic [DW-1:0]  in_quo,
   input  tpde_flags_type in_flags,
   output logic           out_valid,
   input  logic           out_ready,
   output logic [RW-1:0]  out_rem,
   output logic [WP-1:0]  out_div,
   output logic [DW-1:0]  out_quo,
   output tpde_flags_type out_flags
);

   localparam int CW = RW + DW;

   logic           valid_ff;
   logic [CW-1:0]  shifted, diff;
   logic           ge;
   logic [RW-1:0]  rem_in, rem_ff;
   logic [DW-1:0]  quo_in, quo_ff;
   logic [WP-1:0]  div_ff;
   tpde_flags_type flags_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      shifted = CW'(in_div) << SHIFT;
      ge      = CW'(in_rem) >= shifted;
      diff    = CW'(in_rem) - shifted;
      rem_in  = ge ? diff[RW-1:0] : in_rem;
      quo_in  = in_quo | (ge ? (DW'(1) << SHIFT) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rem_ff   <= rem_in;
         div_ff   <= in_div;
         quo_ff   <= quo_in;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_div   = div_ff;
   assign out_quo   = quo_ff;
   assign out_flags = flags_ff;

endmodule

/* rtl/core/tpde_finish.sv */
// Output stage: saturation, sign, status, and the response register.
// Depends on tpde_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "three_point_derivative_estimate_unit_macros.svh"

module tpde_finish import tpde_pkg::*; #(
   parameter int DW = DATA_WIDTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [DW-1:0]  in_quo,
   input  tpde_flags_type in_flags,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [DW-1:0]  slope,
   output status_type     status
);

   localparam logic [DW-1:0] MAXP = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MINN = {1'b1, {(DW-1){1'b0}}};

   logic          valid_ff;
   logic          big;
   logic [DW-1:0] slope_in, slope_ff;
   status_type    status_in, status_ff;

   assign in_ready = !valid_ff || rsp_ready;

   always_comb begin
      // negative results may reach the most negative code, positive ones stop one short
      big = in_flags.neg ? (in_quo[DW-1] && (|in_quo[DW-2:0])) : in_quo[DW-1];
      priority if (in_flags.zero) begin
         slope_in  = '0;
         status_in = ST_DIVZERO;
      end else if (in_flags.ovf || big) begin
         slope_in  = in_flags.neg ? MINN : MAXP;
         status_in = ST_SAT;
      end else begin
         slope_in  = in_flags.neg ? (~in_quo + DW'(1)) : in_quo;
         status_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         slope_ff  <= slope_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign slope     = slope_ff;
   assign status    = status_ff;

   `TPDE_ASSERT_IMP(a_divzero_zero_slope, clock, reset, valid_ff && status_ff == ST_DIVZERO, slope_ff == '0)
   `TPDE_ASSERT_IMP(a_sat_extreme, clock, reset, valid_ff && status_ff == ST_SAT, slope_ff == MAXP || slope_ff == MINN)
   `TPDE_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !valid_ff)

endmodule

/* rtl/core/three_point_derivative_estimate_unit.sv */
// Three-point derivative estimate unit: slope at the first, middle or last of three
// points on a non-uniform grid, signed fixed point. Takes one request per cycle unless
// the response side stalls. Each result passes through seven arithmetic stages, then a
// restoring divider that resolves one quotient bit per stage, then the output stage.
// Coincident abscissae give slope 0 with status 2; quotients outside the output range
// saturate with status 1. Stalls back up stage by stage.
// Depends on tpde_pkg, tpde_arith, tpde_div_step and tpde_finish.
`timescale 1ns / 1ps

module three_point_derivative_estimate_unit import tpde_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // xa, xb, xc, ya, yb, yc from the lowest bit up, zero padded to bytes
   input  logic [((6*DATA_WIDTH+7)/8)*8-1:0]     req_tdata,
   // opcode
   input  logic [1:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // slope, zero padded to bytes
   output logic [((DATA_WIDTH+7)/8)*8-1:0]       rsp_tdata,
   // status
   output logic [1:0]                            rsp_tuser
);

   localparam int DW  = DATA_WIDTH;
   localparam int WP  = 3 * (DW + 1);
   localparam int RW  = WP + 2 + FRAC_BITS;
   localparam int ODW = ((DW + 7) / 8) * 8;

   logic                 dv [DW+1];
   logic                 dr [DW+1];
   logic [RW-1:0]        drem [DW+1];
   logic [WP-1:0]        ddiv [DW+1];
   logic [DW-1:0]        dquo [DW+1];
   tpde_flags_type       dfl [DW+1];
   logic [DW-1:0]        slope_w;
   status_type           status_w;

   tpde_arith #(
      .DW (DW),
      .FB (FRAC_BITS)
   ) u_arith (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_opcode (req_tuser),
      .xa        (req_tdata[DW-1:0]),
      .xb        (req_tdata[2*DW-1:DW]),
      .xc        (req_tdata[3*DW-1:2*DW]),
      .ya        (req_tdata[4*DW-1:3*DW]),
      .yb        (req_tdata[5*DW-1:4*DW]),
      .yc        (req_tdata[6*DW-1:5*DW]),
      .out_valid (dv[0]),
      .out_ready (dr[0]),
      .out_rem   (drem[0]),
      .out_div   (ddiv[0]),
      .out_flags (dfl[0])
   );

   assign dquo[0] = '0;

   // quotient bits from the top down, one per stage
   for (genvar k = 0; k < DW; k++) begin : g_div
      tpde_div_step #(
         .DW    (DW),
         .RW    (RW),
         .WP    (WP),
         .SHIFT (DW - 1 - k)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv[k]),
         .in_ready  (dr[k]),
         .in_rem    (drem[k]),
         .in_div    (ddiv[k]),
         .in_quo    (dquo[k]),
         .in_flags  (dfl[k]),
         .out_valid (dv[k+1]),
         .out_ready (dr[k+1]),
         .out_rem   (drem[k+1]),
         .out_div   (ddiv[k+1]),
         .out_quo   (dquo[k+1]),
         .out_flags (dfl[k+1])
      );
   end

   tpde_finish #(
      .DW (DW)
   ) u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv[DW]),
      .in_ready  (dr[DW]),
      .in_quo    (dquo[DW]),
      .in_flags  (dfl[DW]),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .slope     (slope_w),
      .status    (status_w)
   );

   assign rsp_tdata = ODW'(slope_w);
   assign rsp_tuser = status_w;

endmodule
